// ===== rtl/cpu_schedule_wait_evaluator_macros.svh =====
// ----------------------------------------------------------------------------
// cpu_schedule_wait_evaluator_macros
// Assertion macros for the scheduling wait evaluator.
// Each macro expects signals named clk and rst in the scope of its use.
// ----------------------------------------------------------------------------
`ifndef CPU_SCHEDULE_WAIT_EVALUATOR_MACROS_SVH
`define CPU_SCHEDULE_WAIT_EVALUATOR_MACROS_SVH
`ifndef SYNTHESIS
`define CSWE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("cswe assertion failed");
`define CSWE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cswe assertion failed");
`else
`define CSWE_ASSERT(lbl, prop)
`define CSWE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/cswe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cswe_pkg
// Shared sizes and codes of the scheduling wait evaluator.
// ----------------------------------------------------------------------------
package cswe_pkg;

  // Process store depth and derived index widths.
  localparam int MAX_PROCS = 64;
  localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  // Field widths.
  localparam int TIME_W    = 16;
  localparam int TOTAL_W   = 29;
  localparam int AVG_W     = 31;
  localparam int COUNT_W   = 7;
  localparam int SUM_W     = 32;
  localparam int FRAC_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Simulated time never exceeds the largest arrival plus all bursts.
  localparam int SIM_W     = $clog2((MAX_PROCS + 1) * (1 << TIME_W));

  // Store word: arrival, burst, remaining.
  localparam int MEM_W     = 3 * TIME_W;

  // Average divider.
  localparam int DIV_W     = SUM_W + FRAC_W;
  localparam int DCNT_W    = $clog2(DIV_W);

  // Scheduling policies.
  localparam logic [1:0] POL_FCFS = 2'd0;
  localparam logic [1:0] POL_SJF  = 2'd1;
  localparam logic [1:0] POL_SRTF = 2'd2;
  localparam logic [1:0] POL_RR   = 2'd3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 2'd1;

endpackage
`default_nettype wire

// ===== rtl/cpu_schedule_wait_evaluator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_schedule_wait_evaluator
// Stores processes and evaluates the total and average waiting time under
// first come, shortest job, shortest remaining or round robin scheduling.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Payload
//  input     start, busy             arrival_time, burst_time, last_process
//  result    done (one-cycle pulse)  total_wait, average_wait_q8, process_count
//  config    cfg_valid, cfg_ready    cfg_index, cfg_data
//
// A process is stored on acceptance while there is room; the last item also starts
// the evaluation. First come reads, executes and finishes each process; shortest job
// and shortest remaining scan and decide, plus a finish step per finished process; round
// robin reads and executes per visit, all set by the single store read port. The
// average is then formed in a bit-serial divider and registered for the output.
// Reset is synchronous; busy stays high until the result pulse; no receiver stall.
module cpu_schedule_wait_evaluator (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [cswe_pkg::TIME_W-1:0]    arrival_time,
  input  wire logic [cswe_pkg::TIME_W-1:0]    burst_time,
  input  wire logic                           last_process,
  output logic                                done,
  output logic [cswe_pkg::TOTAL_W-1:0]        total_wait,
  output logic [cswe_pkg::AVG_W-1:0]          average_wait_q8,
  output logic [cswe_pkg::COUNT_W-1:0]        process_count,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cswe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cswe_pkg::CFG_DAT_W-1:0] cfg_data
);
  import cswe_pkg::*;

  `include "cpu_schedule_wait_evaluator_macros.svh"

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_F_RD   = 4'd1;
  localparam logic [3:0] S_F_EX   = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_R_RD   = 4'd5;
  localparam logic [3:0] S_R_EX   = 4'd6;
  localparam logic [3:0] S_FIN    = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  localparam logic [CNT_W-1:0] N_MAX = CNT_W'(MAX_PROCS);

  logic [3:0]             state;
  logic [1:0]             policy;
  logic [TIME_W-1:0]      quantum;
  logic [CNT_W-1:0]       loaded_count;
  logic [CNT_W-1:0]       done_cnt;
  logic [CNT_W-1:0]       scan_idx;
  logic [MAX_PROCS-1:0]   finished;
  logic [SIM_W-1:0]       sim_time;
  logic [SUM_W-1:0]       wait_sum;

  // Scan pipeline and best candidate.
  logic                   dv;
  logic [IDX_W-1:0]       didx;
  logic                   found;
  logic [TIME_W-1:0]      best_key;
  logic [IDX_W-1:0]       best_idx;
  logic [TIME_W-1:0]      best_a;
  logic [TIME_W-1:0]      best_b;
  logic [TIME_W-1:0]      best_r;
  logic                   more;
  logic [TIME_W-1:0]      next_at;

  // Finish stage operands.
  logic [TIME_W-1:0]      fin_a;
  logic [TIME_W-1:0]      fin_b;
  logic [IDX_W-1:0]       fin_idx;

  // Divider.
  logic [DIV_W-1:0]       div_dq;
  logic [CNT_W-1:0]       div_rem;
  logic [DCNT_W-1:0]      div_cnt;

  // Process store.
  logic [MEM_W-1:0]       mem [MAX_PROCS];
  logic [MEM_W-1:0]       rdata;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [MEM_W-1:0]       mem_wdata;

  logic                   accept;
  logic [TIME_W-1:0]      burst_fix;
  logic [TIME_W-1:0]      rd_a;
  logic [TIME_W-1:0]      rd_b;
  logic [TIME_W-1:0]      rd_r;

  // Combinational helpers.
  logic [SIM_W-1:0]       f_start;
  logic [SIM_W-1:0]       f_sim_next;
  logic [CNT_W-1:0]       idx_wrap;
  logic                   last_done;
  logic [SIM_W-1:0]       gap;
  logic [TIME_W-1:0]      run;
  logic [TIME_W-1:0]      srtf_rem;
  logic [SIM_W-1:0]       rr_base;
  logic [TIME_W-1:0]      rr_ex;
  logic [TIME_W-1:0]      rr_rem;
  logic [SIM_W:0]         fin_start;
  logic [SIM_W-1:0]       fin_wait;
  logic [SUM_W:0]         sum_wide;
  logic [SUM_W-1:0]       sum_sat;
  logic [TIME_W-1:0]      scan_key;
  logic                   scan_fin;
  logic                   scan_arrived;
  logic [CNT_W:0]         div_trial;
  logic                   div_bit;
  logic [CNT_W-1:0]       div_rem_next;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign burst_fix = (burst_time == '0) ? TIME_W'(1) : burst_time;

  assign rd_a = rdata[MEM_W-1 -: TIME_W];
  assign rd_b = rdata[2*TIME_W-1 -: TIME_W];
  assign rd_r = rdata[TIME_W-1:0];

  // Datapath for each step.
  always_comb begin
    f_start    = (sim_time < SIM_W'(rd_a)) ? SIM_W'(rd_a) : sim_time;
    f_sim_next = f_start + SIM_W'(rd_b);
    idx_wrap   = (scan_idx + CNT_W'(1) == loaded_count) ? '0 : scan_idx + CNT_W'(1);
    last_done  = (done_cnt + CNT_W'(1) == loaded_count);

    gap      = SIM_W'(next_at) - sim_time;
    run      = (more && (gap < SIM_W'(best_r))) ? gap[TIME_W-1:0] : best_r;
    srtf_rem = best_r - run;

    rr_base = (sim_time < SIM_W'(rd_a)) ? SIM_W'(rd_a) : sim_time;
    rr_ex   = (rd_r > quantum) ? quantum : rd_r;
    rr_rem  = rd_r - rr_ex;

    fin_start = (SIM_W+1)'(fin_a) + (SIM_W+1)'(fin_b);
    fin_wait  = ({1'b0, sim_time} > fin_start) ?
                SIM_W'({1'b0, sim_time} - fin_start) : '0;
    sum_wide  = {1'b0, wait_sum} + (SUM_W+1)'(fin_wait);
    sum_sat   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

    scan_key     = (policy == POL_SJF) ? rd_b : rd_r;
    scan_fin     = finished[didx];
    scan_arrived = (SIM_W'(rd_a) <= sim_time);

    div_trial    = {div_rem, div_dq[DIV_W-1]};
    div_bit      = (div_trial >= (CNT_W+1)'(loaded_count));
    div_rem_next = div_bit ? CNT_W'(div_trial - (CNT_W+1)'(loaded_count))
                           : div_trial[CNT_W-1:0];
  end

  // Store write port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = scan_idx[IDX_W-1:0];
    mem_wdata = {rd_a, rd_b, rr_rem};
    case (state)
      S_IDLE: begin
        mem_we    = accept && (loaded_count < N_MAX);
        mem_waddr = loaded_count[IDX_W-1:0];
        mem_wdata = {arrival_time, burst_fix, burst_fix};
      end
      S_DECIDE: begin
        mem_we    = found && (policy == POL_SRTF);
        mem_waddr = best_idx;
        mem_wdata = {best_a, best_b, srtf_rem};
      end
      S_R_EX: begin
        mem_we = (rd_r != '0);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Process store with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[scan_idx[IDX_W-1:0]];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      policy  <= POL_FCFS;
      quantum <= TIME_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POLICY:  policy  <= cfg_data[1:0];
        CFG_QUANTUM: quantum <= (cfg_data == '0) ? TIME_W'(1) : cfg_data;
        default:     ;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      loaded_count <= '0;
      finished     <= '0;
      done         <= 1'b0;
      dv           <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (loaded_count < N_MAX) begin
              loaded_count <= loaded_count + CNT_W'(1);
            end
            if (last_process) begin
              sim_time <= '0;
              wait_sum <= '0;
              done_cnt <= '0;
              scan_idx <= '0;
              found    <= 1'b0;
              more     <= 1'b0;
              dv       <= 1'b0;
              case (policy)
                POL_FCFS: state <= S_F_RD;
                POL_RR:   state <= S_R_RD;
                default:  state <= S_SCAN;
              endcase
            end
          end
        end

        // First come: one process per read.
        S_F_RD: state <= S_F_EX;
        S_F_EX: begin
          sim_time <= f_sim_next;
          fin_a    <= rd_a;
          fin_b    <= rd_b;
          fin_idx  <= scan_idx[IDX_W-1:0];
          state    <= S_FIN;
        end

        // Pipelined scan for the shortest candidate and the next arrival.
        S_SCAN: begin
          if (scan_idx != loaded_count) begin
            dv       <= 1'b1;
            didx     <= scan_idx[IDX_W-1:0];
            scan_idx <= scan_idx + CNT_W'(1);
          end else begin
            dv <= 1'b0;
          end
          if (dv && !scan_fin) begin
            if (scan_arrived) begin
              if (!found || scan_key < best_key) begin
                found    <= 1'b1;
                best_key <= scan_key;
                best_idx <= didx;
                best_a   <= rd_a;
                best_b   <= rd_b;
                best_r   <= rd_r;
              end
            end else if (!more || rd_a < next_at) begin
              more    <= 1'b1;
              next_at <= rd_a;
            end
          end
          if (scan_idx == loaded_count && !dv) begin
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          scan_idx <= '0;
          found    <= 1'b0;
          more     <= 1'b0;
          fin_a    <= best_a;
          fin_b    <= best_b;
          fin_idx  <= best_idx;
          if (!found) begin
            if (more) begin
              sim_time <= SIM_W'(next_at);
              state    <= S_SCAN;
            end else begin
              state <= S_DIV;
            end
          end else if (policy == POL_SJF) begin
            sim_time <= sim_time + SIM_W'(best_b);
            state    <= S_FIN;
          end else begin
            sim_time <= sim_time + SIM_W'(run);
            state    <= (srtf_rem == '0) ? S_FIN : S_SCAN;
          end
          if (!found && !more) begin
            div_dq  <= {wait_sum, FRAC_W'(0)};
            div_rem <= '0;
            div_cnt <= '0;
          end
        end

        // Round robin: one visit per read.
        S_R_RD: state <= S_R_EX;
        S_R_EX: begin
          if (rd_r == '0) begin
            scan_idx <= idx_wrap;
            state    <= S_R_RD;
          end else begin
            sim_time <= rr_base + SIM_W'(rr_ex);
            fin_a    <= rd_a;
            fin_b    <= rd_b;
            fin_idx  <= scan_idx[IDX_W-1:0];
            if (rr_rem == '0) begin
              state <= S_FIN;
            end else begin
              scan_idx <= idx_wrap;
              state    <= S_R_RD;
            end
          end
        end

        // A process finishes: add its wait.
        S_FIN: begin
          finished[fin_idx] <= 1'b1;
          wait_sum          <= sum_sat;
          done_cnt          <= done_cnt + CNT_W'(1);
          div_dq            <= {sum_sat, FRAC_W'(0)};
          div_rem           <= '0;
          div_cnt           <= '0;
          case (policy)
            POL_FCFS: begin
              scan_idx <= scan_idx + CNT_W'(1);
              state    <= last_done ? S_DIV : S_F_RD;
            end
            POL_RR: begin
              scan_idx <= idx_wrap;
              state    <= last_done ? S_DIV : S_R_RD;
            end
            default: begin
              scan_idx <= '0;
              state    <= last_done ? S_DIV : S_SCAN;
            end
          endcase
        end

        // Restoring division, one quotient bit per cycle.
        S_DIV: begin
          div_dq  <= {div_dq[DIV_W-2:0], div_bit};
          div_rem <= div_rem_next;
          div_cnt <= div_cnt + DCNT_W'(1);
          if (div_cnt == DCNT_W'(DIV_W - 1)) begin
            state <= S_OUT;
          end
        end

        S_OUT: begin
          total_wait      <= (wait_sum > SUM_W'({TOTAL_W{1'b1}})) ?
                             '1 : wait_sum[TOTAL_W-1:0];
          average_wait_q8 <= (div_dq > DIV_W'({AVG_W{1'b1}})) ?
                             '1 : div_dq[AVG_W-1:0];
          process_count   <= COUNT_W'(loaded_count);
          done            <= 1'b1;
          loaded_count    <= '0;
          finished        <= '0;
          state           <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks.
  `CSWE_ASSERT(a_done_idle, !done || (state == S_IDLE))
  `CSWE_ASSERT_NEXT(a_done_pulse, done, !done)
  `CSWE_ASSERT(a_div_all_done, (state != S_DIV) || (done_cnt == loaded_count))
  `CSWE_ASSERT(a_count_nonzero, !done || (process_count != '0))
  `CSWE_ASSERT_NEXT(a_last_busy, accept && last_process, busy)

endmodule
`default_nettype wire

// ===== tb/cpu_schedule_wait_evaluator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_schedule_wait_evaluator_tb
// Loads process sets into the wait evaluator under all four policies and
// compares every total, average and count with a behavioral scheduler, or with the
// typed expectation of a directed row that has chk set.
module cpu_schedule_wait_evaluator_tb;
  import cswe_pkg::*;

  localparam int                   CLK_HALF   = 4;
  localparam int                   WDOG_LIMIT = 200000;
  localparam int                   ITEM_GOAL  = 1700;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [AVG_W-1:0]   avg;
    logic [COUNT_W-1:0] count;
  } wait_res_t;

  // One row of the directed table; a set of registers is written before the
  // row when new_cfg is set, and the typed expectation is used when chk is set.
  typedef struct {
    bit                new_cfg;
    logic [1:0]        pol;
    logic [15:0]       qnt;
    logic [TIME_W-1:0] arr;
    logic [TIME_W-1:0] bur;
    bit                last;
    bit                chk;
    wait_res_t         res;
  } row_t;

  logic clk, rst;
  logic start, busy, last_process, done;
  logic [TIME_W-1:0]    arrival_time, burst_time;
  logic [TOTAL_W-1:0]   total_wait;
  logic [AVG_W-1:0]     average_wait_q8;
  logic [COUNT_W-1:0]   process_count;
  logic                 cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  cpu_schedule_wait_evaluator u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .arrival_time(arrival_time), .burst_time(burst_time),
    .last_process(last_process), .done(done), .total_wait(total_wait),
    .average_wait_q8(average_wait_q8), .process_count(process_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Scheduler state kept by the testbench.
  logic [TIME_W-1:0] proc_arr [MAX_PROCS];
  logic [TIME_W-1:0] proc_bur [MAX_PROCS];
  logic [TIME_W-1:0] proc_left[MAX_PROCS];
  bit                proc_done[MAX_PROCS];
  int                n_loaded;
  logic [1:0]        cur_policy;
  logic [15:0]       cur_quantum;
  longint            sched_clk;
  longint unsigned   wait_acc;

  wait_res_t pending_q[$];
  int        err_count;
  int        idle_cycles;
  int        items_sent;
  bit        gaps_on;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // Retire process k at the current schedule time and add its wait.
  function automatic void retire(input int k);
    longint fin_at;
    fin_at = longint'(proc_arr[k]) + longint'(proc_bur[k]);
    if (sched_clk > fin_at) wait_acc += longint'(sched_clk - fin_at);
    if (wait_acc > 64'hFFFF_FFFF) wait_acc = 64'hFFFF_FFFF;
    proc_done[k] = 1'b1;
  endfunction

  // Earliest arrival later than now among unfinished processes.
  function automatic bit next_arrival(input int n, output longint at);
    bit found;
    found = 0;
    at = 0;
    for (int i = 0; i < n; i++)
      if (!proc_done[i] && proc_arr[i] > sched_clk && (!found || proc_arr[i] < at)) begin
        at = proc_arr[i];
        found = 1;
      end
    return found;
  endfunction

  // Shortest job, or shortest remaining time when preempt is set.
  function automatic void run_shortest(input int n, input bit preempt);
    int     finished, pick;
    longint best, v, na, slice;
    bit     found, more;
    finished = 0;
    while (finished < n) begin
      found = 0;
      pick = 0;
      best = 0;
      for (int i = 0; i < n; i++) begin
        v = preempt ? proc_left[i] : proc_bur[i];
        if (!proc_done[i] && proc_arr[i] <= sched_clk && (!found || v < best)) begin
          best = v;
          pick = i;
          found = 1;
        end
      end
      more = next_arrival(n, na);
      if (!found) begin
        if (!more) break;
        sched_clk = na;
      end else if (!preempt) begin
        sched_clk += proc_bur[pick];
        retire(pick);
        finished++;
      end else begin
        // The chosen process keeps the processor until it finishes or the next arrival.
        slice = proc_left[pick];
        if (more && na - sched_clk < slice) slice = na - sched_clk;
        proc_left[pick] = proc_left[pick] - TIME_W'(slice);
        sched_clk += slice;
        if (proc_left[pick] == 0) begin
          retire(pick);
          finished++;
        end
      end
    end
  endfunction

  // Evaluate the stored set under the current policy.
  function automatic wait_res_t evaluate_set();
    int              n, left;
    longint          ex;
    longint unsigned avg;
    wait_res_t       r;
    n = n_loaded;
    for (int i = 0; i < n; i++) begin
      proc_left[i] = proc_bur[i];
      proc_done[i] = 1'b0;
    end
    sched_clk = 0;
    wait_acc  = 0;
    case (cur_policy)
      POL_FCFS: begin
        for (int i = 0; i < n; i++) begin
          if (sched_clk < proc_arr[i]) sched_clk = proc_arr[i];
          sched_clk += proc_bur[i];
          retire(i);
        end
      end
      POL_SJF:  run_shortest(n, 1'b0);
      POL_SRTF: run_shortest(n, 1'b1);
      default: begin
        // Round robin in index order, waiting for late arrivals.
        left = n;
        while (left > 0)
          for (int i = 0; i < n; i++) begin
            if (proc_left[i] == 0) continue;
            if (sched_clk < proc_arr[i]) sched_clk = proc_arr[i];
            ex = proc_left[i];
            if (ex > cur_quantum) ex = cur_quantum;
            proc_left[i] = proc_left[i] - TIME_W'(ex);
            sched_clk += ex;
            if (proc_left[i] == 0) begin
              retire(i);
              left--;
            end
          end
      end
    endcase
    r.total = (wait_acc > 64'h1FFF_FFFF) ? '1 : TOTAL_W'(wait_acc);
    avg = (n != 0) ? (wait_acc << 8) / n : 0;
    r.avg = (avg > 64'h7FFF_FFFF) ? '1 : AVG_W'(avg);
    r.count = COUNT_W'(n);
    for (int i = 0; i < MAX_PROCS; i++) proc_done[i] = 1'b0;
    n_loaded = 0;
    return r;
  endfunction

  // Store one accepted process; returns 1 with a result on the last one.
  function automatic bit load_process(input logic [TIME_W-1:0] at,
                                      input logic [TIME_W-1:0] bt,
                                      input bit last, output wait_res_t r);
    if (bt == 0) bt = 1;
    if (n_loaded < MAX_PROCS) begin
      proc_arr[n_loaded] = at;
      proc_bur[n_loaded] = bt;
      n_loaded++;
    end
    if (last) r = evaluate_set();
    return last;
  endfunction

  // Result checker: every pulse must match the oldest pending result.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        report("unexpected result, total", total_wait, 0);
      end else begin
        if (total_wait != pending_q[0].total)
          report("total_wait", total_wait, pending_q[0].total);
        if (average_wait_q8 != pending_q[0].avg)
          report("average_wait_q8", average_wait_q8, pending_q[0].avg);
        if (process_count != pending_q[0].count)
          report("process_count", process_count, pending_q[0].count);
        void'(pending_q.pop_front());
      end
    end
  end

  // Watchdog on cycles with no handshake of any kind.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one process; called at a falling edge, returns at a falling edge.
  task automatic send_process(input logic [TIME_W-1:0] at, input logic [TIME_W-1:0] bt,
                              input bit last, input bit typed, input wait_res_t want);
    wait_res_t r;
    bit        tail;
    tail = items_sent > ITEM_GOAL - ITEM_GOAL / 8;
    if (gaps_on && !tail && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    start        = 1'b1;
    arrival_time = at;
    burst_time   = bt;
    last_process = last;
    do @(posedge clk); while (busy);
    if (load_process(at, bt, last, r)) pending_q.push_back(typed ? want : r);
    items_sent++;
    @(negedge clk);
  endtask

  // Pause until every result is in, then let loads settle.
  task automatic drain();
    start = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_POLICY) cur_policy = val[1:0];
    else if (idx == CFG_QUANTUM) cur_quantum = (val == 0) ? 16'd1 : val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_mode(input logic [1:0] pol, input logic [15:0] qnt);
    drain();
    write_reg(CFG_POLICY, pol);
    write_reg(CFG_QUANTUM, qnt);
  endtask

  row_t rows[] = '{
    // Defaults after reset: first come, single process.
    '{0, POL_FCFS, 1, 0, 5, 1, 1, '{0, 0, 1}},
    // Zero burst taken as one, then the longest burst.
    '{0, POL_FCFS, 1, 0, 0, 0, 0, '{0, 0, 0}},
    '{0, POL_FCFS, 1, 0, 16'hFFFF, 1, 1, '{1, 128, 2}},
    '{0, POL_FCFS, 1, 16'hFFFF, 16'hFFFF, 1, 1, '{0, 0, 1}},
    // Shortest job with a tie on burst.
    '{1, POL_SJF, 1, 0, 10, 0, 0, '{0, 0, 0}},
    '{0, POL_SJF, 1, 1, 3, 0, 0, '{0, 0, 0}},
    '{0, POL_SJF, 1, 2, 3, 1, 0, '{0, 0, 0}},
    // Shortest job with idle time before a late arrival.
    '{0, POL_SJF, 1, 40, 5, 0, 0, '{0, 0, 0}},
    '{0, POL_SJF, 1, 0, 1, 1, 0, '{0, 0, 0}},
    // Shortest remaining with preemption.
    '{1, POL_SRTF, 1, 0, 8, 0, 0, '{0, 0, 0}},
    '{0, POL_SRTF, 1, 1, 4, 0, 0, '{0, 0, 0}},
    '{0, POL_SRTF, 1, 2, 9, 0, 0, '{0, 0, 0}},
    '{0, POL_SRTF, 1, 3, 5, 1, 0, '{0, 0, 0}},
    // Shortest remaining with idle time before a late arrival.
    '{0, POL_SRTF, 1, 100, 3, 0, 0, '{0, 0, 0}},
    '{0, POL_SRTF, 1, 5, 2, 1, 0, '{0, 0, 0}},
    // Round robin, zero quantum taken as one.
    '{1, POL_RR, 0, 0, 3, 0, 0, '{0, 0, 0}},
    '{0, POL_RR, 0, 0, 2, 1, 0, '{0, 0, 0}},
    // Round robin with the largest quantum.
    '{1, POL_RR, 16'hFFFF, 0, 16'hFFFF, 0, 0, '{0, 0, 0}},
    '{0, POL_RR, 16'hFFFF, 10, 5, 1, 0, '{0, 0, 0}},
    // Round robin stalling on a process that has not arrived.
    '{1, POL_RR, 2, 0, 2, 0, 0, '{0, 0, 0}},
    '{0, POL_RR, 2, 50, 4, 0, 0, '{0, 0, 0}},
    '{0, POL_RR, 2, 1, 3, 1, 0, '{0, 0, 0}}
  };

  initial begin
    int                set_len, phases, burst_cap;
    bit                wide;
    logic [TIME_W-1:0] a, b;
    rst          = 1'b1;
    start        = 1'b0;
    arrival_time = '0;
    burst_time   = '0;
    last_process = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_POLICY;
    cfg_data     = '0;
    err_count    = 0;
    items_sent   = 0;
    n_loaded     = 0;
    cur_policy   = POL_FCFS;
    cur_quantum  = 16'd1;
    gaps_on      = 1'b1;
    for (int i = 0; i < MAX_PROCS; i++) proc_done[i] = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Writes to unused register indexes must be ignored.
    write_reg(CFG_SPARE2, 16'(($urandom())));
    write_reg(CFG_SPARE3, 16'hFFFF);

    // Directed table.
    foreach (rows[i]) begin
      if (rows[i].new_cfg) set_mode(rows[i].pol, rows[i].qnt);
      send_process(rows[i].arr, rows[i].bur, rows[i].last, rows[i].chk, rows[i].res);
    end

    // Full store: the extra items are dropped and the last still evaluates.
    set_mode(POL_FCFS, 1);
    for (int i = 0; i < MAX_PROCS + 2; i++)
      send_process(16'(i * 3), 16'(i % 7), i == MAX_PROCS + 1, 0, '0);

    // Random phases of one setting each, with whole process sets.
    while (items_sent < ITEM_GOAL) begin
      case ($urandom_range(0, 5))
        0:       set_mode(2'($urandom_range(0, 3)), 16'hFFFF);
        1:       set_mode(2'($urandom_range(0, 3)), 16'd1);
        2:       set_mode(2'($urandom_range(0, 3)), 16'd0);
        default: set_mode(2'($urandom_range(0, 3)), 16'($urandom_range(1, 20)));
      endcase
      gaps_on = $urandom_range(0, 3) != 0;
      phases  = $urandom_range(1, 6);
      repeat (phases) begin
        case ($urandom_range(0, 19))
          0:       set_len = $urandom_range(MAX_PROCS - 1, MAX_PROCS + 3);
          1, 2:    set_len = $urandom_range(9, 24);
          default: set_len = $urandom_range(1, 8);
        endcase
        wide = $urandom_range(0, 4) == 0;
        // Round robin cost grows with burst over quantum, so keep that ratio bounded.
        burst_cap = (cur_policy == POL_RR) ? cur_quantum * 4 : 16'hFFFF;
        if (burst_cap > 16'hFFFF) burst_cap = 16'hFFFF;
        for (int i = 0; i < set_len; i++) begin
          a = wide ? 16'($urandom()) : 16'($urandom_range(0, set_len * 8));
          if (wide && $urandom_range(0, 1)) b = 16'($urandom_range(0, burst_cap));
          else b = 16'($urandom_range(0, (burst_cap < 15) ? burst_cap : 15));
          send_process(a, b, i == set_len - 1, 0, '0);
        end
      end
    end

    // Wind down: all results in, then a short settle.
    start = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (err_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cswe_pkg.sv
rtl/cpu_schedule_wait_evaluator.sv
tb/cpu_schedule_wait_evaluator_tb.sv
